// File: src/bfhd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfhd_pkg
// Types, constants and lookup functions of the box-filter Hessian block.
// ----------------------------------------------------------------------------
package bfhd_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int POINTS     = 40;
  localparam int NUM_W      = 72;
  localparam int DV_W       = 27;
  localparam int QUO_W      = 48;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;

  typedef struct packed {
    logic        action;
    logic [6:0]  pos_x;
    logic [6:0]  pos_y;
    logic [31:0] integral_word;
  } in_t;

  typedef struct packed {
    logic signed [47:0] determinant;
    logic               in_interior;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DRAIN, S_MUL1, S_MUL2, S_SCALE, S_COMB, S_DSTART, S_DIV, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    O_HM1, O_SM1, O_SP, O_HP, O_HN, O_SN, O_Z, O_HPM1
  } ofs_t;

  typedef enum logic [1:0] { W_P1, W_M1, W_M2 } wgt_t;
  typedef enum logic [1:0] { T_YY, T_XX, T_XY } tgt_t;

  typedef struct packed {
    ofs_t ra;
    ofs_t ca;
    ofs_t rb;
    ofs_t cb;
    wgt_t w;
    tgt_t t;
  } box_t;

  typedef struct packed {
    logic done;
    logic overflow;
  } div_status_t;

  function automatic box_t box_info(input logic [3:0] b);
    box_t r;
    case (b)
      4'd0:    r = '{O_HM1, O_SM1, O_SM1, O_SP,   W_P1, T_YY};
      4'd1:    r = '{O_SM1, O_SM1, O_SP,  O_SP,   W_M2, T_YY};
      4'd2:    r = '{O_SP,  O_SM1, O_HP,  O_SP,   W_P1, T_YY};
      4'd3:    r = '{O_SM1, O_HM1, O_SP,  O_SM1,  W_P1, T_XX};
      4'd4:    r = '{O_SM1, O_SM1, O_SP,  O_SP,   W_M2, T_XX};
      4'd5:    r = '{O_SM1, O_SP,  O_SP,  O_HP,   W_P1, T_XX};
      4'd6:    r = '{O_HN,  O_HN,  O_SN,  O_SN,   W_P1, T_XY};
      4'd7:    r = '{O_HN,  O_Z,   O_SN,  O_HPM1, W_M1, T_XY};
      4'd8:    r = '{O_Z,   O_HN,  O_HPM1, O_SN,  W_M1, T_XY};
      4'd9:    r = '{O_Z,   O_Z,   O_HPM1, O_HPM1, W_P1, T_XY};
      default: r = '{O_Z,   O_Z,   O_Z,   O_Z,    W_P1, T_XY};
    endcase
    return r;
  endfunction

  // Half size L/2 of the filter.
  function automatic logic [4:0] half_size(input logic [2:0] s);
    case (s)
      3'd0:    return 5'd4;
      3'd1:    return 5'd7;
      3'd2:    return 5'd10;
      3'd3:    return 5'd13;
      default: return 5'd16;
    endcase
  endfunction

  // Lobe offset L/6.
  function automatic logic [2:0] sixth_size(input logic [2:0] s);
    case (s)
      3'd0:    return 3'd1;
      3'd1:    return 3'd2;
      3'd2:    return 3'd3;
      3'd3:    return 3'd4;
      default: return 3'd5;
    endcase
  endfunction

  // Divisor 100 * L^4.
  function automatic logic [DV_W-1:0] divisor(input logic [2:0] s);
    case (s)
      3'd0:    return 27'd656100;
      3'd1:    return 27'd5062500;
      3'd2:    return 27'd19448100;
      3'd3:    return 27'd53144100;
      default: return 27'd118592100;
    endcase
  endfunction

  function automatic logic signed [6:0] offset(input ofs_t c, input logic [4:0] h,
                                               input logic [2:0] s6);
    logic signed [6:0] hs;
    logic signed [6:0] ss;
    hs = signed'({2'b00, h});
    ss = signed'({4'b0000, s6});
    case (c)
      O_HM1:   return -hs - 7'sd1;
      O_SM1:   return -ss - 7'sd1;
      O_SP:    return ss;
      O_HP:    return hs;
      O_HN:    return -hs;
      O_SN:    return -ss;
      O_Z:     return 7'sd0;
      O_HPM1:  return hs - 7'sd1;
      default: return 7'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: src/bfhd_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfhd_divider
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / dv).
// ----------------------------------------------------------------------------
module bfhd_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [bfhd_pkg::NUM_W-1:0]  num,
  input  wire logic [bfhd_pkg::DV_W-1:0]   dv,
  output bfhd_pkg::div_status_t            status,
  output logic [bfhd_pkg::QUO_W-1:0]       quotient
);
  import bfhd_pkg::*;

  logic                 run_r, run_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic [DV_W-1:0]      rem_r, rem_nxt;
  logic [QUO_W-1:0]     low_r, low_nxt;
  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic                 done_r, done_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [DV_W:0]        trial;
  logic                 fits;

  assign trial = {rem_r, low_r[QUO_W-1]};
  assign fits  = trial >= {1'b0, dv};

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    if (start) begin
      // The quotient only fits in 48 bits when the top part is below dv.
      if (num[NUM_W-1:32] >= {13'd0, dv}) begin
        ovf_nxt  = 1'b1;
        done_nxt = 1'b1;
      end else begin
        ovf_nxt = 1'b0;
        run_nxt = 1'b1;
        cnt_nxt = 6'd0;
        rem_nxt = num[32+DV_W-1:32];
        low_nxt = {num[31:0], 16'd0};
      end
    end else if (run_r) begin
      rem_nxt = fits ? DV_W'(trial - {1'b0, dv}) : trial[DV_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      low_nxt = {low_r[QUO_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(QUO_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      ovf_r  <= ovf_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign status   = '{done: done_r, overflow: ovf_r};
  assign quotient = quo_r;

  ap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r) else $error("divider restarted while running");
  ap_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held longer than one cycle");
  ap_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> cnt_r < 6'(QUO_W)) else $error("divider count out of range");

endmodule
`default_nettype wire

// File: src/box_filter_hessian_determinant.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_hessian_determinant
// Integral image store with a box-filter Hessian determinant query.
// ----------------------------------------------------------------------------
// A write beat (action 0) stores one integral word when its position lies
// inside the image, and produces no result. A query beat (action 1) produces
// exactly one result, shown for one cycle on out_valid; the receiver cannot
// stall it. A query outside the interior band goes straight to the done state
// with a zero determinant. An interior query reads its 40 corner points
// through the single memory port, then uses the shared 32x32 multiplier and
// the scaling adders, and ends in the bit-serial divider by 100*L^4. Busy
// stays high for the whole query. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module box_filter_hessian_determinant (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire bfhd_pkg::in_t in_data,
  output logic               out_valid,
  output bfhd_pkg::out_t     out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [7:0]    cfg_data
);
  import bfhd_pkg::*;

  // Configuration registers and their effective values.
  logic [7:0] width_r, height_r;
  logic [2:0] scale_r;
  logic [7:0] w_eff, h_eff;
  logic [2:0] s_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd128;
      height_r <= 8'd128;
      scale_r  <= 3'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_SCALE:  scale_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (width_r == 8'd0) ? 8'd1 :
            (width_r > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : width_r;
    h_eff = (height_r == 8'd0) ? 8'd1 :
            (height_r > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : height_r;
    s_eff = (scale_r > 3'd4) ? 3'd4 : scale_r;
  end

  logic [4:0]       h2;
  logic [2:0]       s6;
  assign h2 = half_size(s_eff);
  assign s6 = sixth_size(s_eff);

  // Sequencer state.
  state_t           state_r, state_nxt;
  logic [5:0]       k_r, k_nxt;
  logic [6:0]       qx_r, qy_r;
  logic             accept, do_write, do_query, interior;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign do_write = accept && (in_data.action == ACT_WRITE) &&
                    ({1'b0, in_data.pos_x} < w_eff) && ({1'b0, in_data.pos_y} < h_eff);
  assign do_query = accept && (in_data.action == ACT_QUERY);

  // Interior band: H+1 <= x < W-H-1, same for y.
  logic signed [9:0] lo_b, hi_x, hi_y, px, py;
  always_comb begin
    lo_b = signed'(10'(h2)) + 10'sd1;
    hi_x = signed'(10'(w_eff)) - signed'(10'(h2)) - 10'sd1;
    hi_y = signed'(10'(h_eff)) - signed'(10'(h2)) - 10'sd1;
    px   = signed'(10'(in_data.pos_x));
    py   = signed'(10'(in_data.pos_y));
    interior = (px >= lo_b) && (px < hi_x) && (py >= lo_b) && (py < hi_y);
  end

  // Corner point of the current read step.
  box_t              bi;
  ofs_t              rc, cc;
  logic signed [7:0] row_s, col_s;
  logic [6:0]        row, col;
  logic [ADDR_W:0]   addr_full;
  logic [ADDR_W-1:0] addr;

  always_comb begin
    bi    = box_info(k_r[5:2]);
    rc    = (k_r[1:0] == 2'd0 || k_r[1:0] == 2'd2) ? bi.ra : bi.rb;
    cc    = (k_r[1:0] == 2'd0 || k_r[1:0] == 2'd3) ? bi.ca : bi.cb;
    row_s = signed'({1'b0, qy_r}) + 8'(offset(rc, h2, s6));
    col_s = signed'({1'b0, qx_r}) + 8'(offset(cc, h2, s6));
    row   = busy ? row_s[6:0] : in_data.pos_y;
    col   = busy ? col_s[6:0] : in_data.pos_x;
    addr_full = (ADDR_W+1)'(row * w_eff) + (ADDR_W+1)'(col);
    addr      = addr_full[ADDR_W-1:0];
  end

  // Integral image memory, one port.
  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] mem_q_r;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[addr] <= in_data.integral_word;
    end else begin
      mem_q_r <= mem[addr];
    end
  end

  // Accumulation of the three responses, one point per cycle.
  logic        rdv_r;
  logic [5:0]  kd_r;
  box_t        bd;
  logic [31:0] term;
  logic        sub;
  logic [31:0] dyy_r, dxx_r, dxy_r;

  always_comb begin
    bd   = box_info(kd_r[5:2]);
    term = (bd.w == W_M2) ? {mem_q_r[30:0], 1'b0} : mem_q_r;
    sub  = (bd.w != W_P1) ^ kd_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
    end else begin
      rdv_r <= (state_r == S_READ);
    end
    kd_r <= k_r;
    if (do_query) begin
      dyy_r <= 32'd0;
      dxx_r <= 32'd0;
      dxy_r <= 32'd0;
    end else if (rdv_r) begin
      case (bd.t)
        T_YY:    dyy_r <= sub ? dyy_r - term : dyy_r + term;
        T_XX:    dxx_r <= sub ? dxx_r - term : dxx_r + term;
        default: dxy_r <= sub ? dxy_r - term : dxy_r + term;
      endcase
    end
  end

  // Shared 32x32 multiplier and the scaling/combining steps.
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;
  logic [63:0]      ma_r, mb_r;
  logic [NUM_W-1:0] m1_r, m2_r, num_r;
  logic             neg_r, inter_r;
  logic [31:0]      axx, ayy, axy;

  assign axx = dxx_r[31] ? 32'd0 - dxx_r : dxx_r;
  assign ayy = dyy_r[31] ? 32'd0 - dyy_r : dyy_r;
  assign axy = dxy_r[31] ? 32'd0 - dxy_r : dxy_r;
  assign mul_a = (state_r == S_MUL1) ? axx : axy;
  assign mul_b = (state_r == S_MUL1) ? ayy : axy;
  assign prod  = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    if (state_r == S_MUL1) ma_r <= prod;
    if (state_r == S_MUL2) mb_r <= prod;
    if (state_r == S_SCALE) begin
      m1_r <= (NUM_W'(ma_r) << 6) + (NUM_W'(ma_r) << 5) + (NUM_W'(ma_r) << 2);
      m2_r <= (NUM_W'(mb_r) << 6) + (NUM_W'(mb_r) << 4) + NUM_W'(mb_r);
    end
    if (state_r == S_COMB) begin
      if ((dxx_r[31] != dyy_r[31]) && (ma_r != 64'd0)) begin
        num_r <= m1_r + m2_r;
        neg_r <= 1'b1;
      end else if (m1_r < m2_r) begin
        num_r <= m2_r - m1_r;
        neg_r <= 1'b1;
      end else begin
        num_r <= m1_r - m2_r;
        neg_r <= 1'b0;
      end
    end
    if (do_query) begin
      qx_r    <= in_data.pos_x;
      qy_r    <= in_data.pos_y;
      inter_r <= interior;
    end
  end

  div_status_t      dst;
  logic [QUO_W-1:0] quo;

  bfhd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DSTART),
    .num      (num_r),
    .dv       (divisor(s_eff)),
    .status   (dst),
    .quotient (quo)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      S_IDLE: begin
        k_nxt = 6'd0;
        if (do_query) state_nxt = interior ? S_READ : S_DONE;
      end
      S_READ: begin
        k_nxt = k_r + 6'd1;
        if (k_r == 6'(POINTS - 1)) state_nxt = S_DRAIN;
      end
      S_DRAIN:  state_nxt = S_MUL1;
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_SCALE;
      S_SCALE:  state_nxt = S_COMB;
      S_COMB:   state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DIV;
      S_DIV: begin
        if (dst.done) state_nxt = S_DONE;
      end
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Result formatting with saturation.
  out_t        res;
  logic [47:0] mag;
  always_comb begin
    res = '0;
    mag = quo;
    if (inter_r) begin
      if (neg_r) begin
        if (dst.overflow || (quo > 48'h8000_0000_0000)) mag = 48'h8000_0000_0000;
        res.determinant = signed'(48'd0 - mag);
      end else begin
        if (dst.overflow || quo[47]) mag = 48'h7FFF_FFFF_FFFF;
        res.determinant = signed'(mag);
      end
      res.in_interior = 1'b1;
    end
  end

  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= (state_r == S_DONE);
    end
    if (state_r == S_DONE) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ap_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE) else $error("result strobe outside idle");
  ap_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> k_r < 6'(POINTS)) else $error("read step out of range");
  ap_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    dst.done |-> state_r == S_DIV) else $error("divider finished outside divide state");

endmodule
`default_nettype wire

// File: test/box_filter_hessian_determinant_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_filter_hessian_determinant_test
// Self-checking bench for the integral image store and its Hessian query.
// ----------------------------------------------------------------------------
// The stimulus process fills a queue of beats phase by phase. Between phases
// it drains the block and rewrites the geometry and scale registers. A clocked
// driver pulls beats from that queue with random gaps, and the same block runs
// a private model of the store and of the determinant on every accepted beat.
// A clocked monitor compares each result strobe against the oldest prediction.
// Queries only land where every integral word they touch has been written.
// ----------------------------------------------------------------------------
module box_filter_hessian_determinant_test;
  import bfhd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_BEATS = 120;

  typedef struct {
    in_t beat;
    bit  drain;
  } job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  box_filter_hessian_determinant DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Beats waiting to be sent, and determinants waiting to come back.
  job_t job_q[$];
  out_t det_expected_q[$];
  int   send_idle_pct = 16;
  int   errors = 0;
  int   results_seen = 0;
  int   cycles = 0;

  // Private copy of the block: integral store and the three registers.
  logic [31:0] integral_model [MEM_DEPTH];
  logic [7:0]  width_reg = 8'd128;
  logic [7:0]  height_reg = 8'd128;
  logic [2:0]  scale_reg = 3'd0;

  // A geometry register of 0 behaves as 1, anything past the maximum as the max.
  function automatic int clamp_dim(input int v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Scale codes above 4 behave as the largest filter.
  function automatic int filter_len(input int s);
    case (s)
      0:       return 9;
      1:       return 15;
      2:       return 21;
      3:       return 27;
      default: return 33;
    endcase
  endfunction

  function automatic bit in_band(input int x, input int y, input int w, input int h,
                                 input int len);
    int hl;
    hl = len / 2;
    return x >= hl + 1 && x < w - hl - 1 && y >= hl + 1 && y < h - hl - 1;
  endfunction

  // Corner read; anything off the image reads as zero.
  function automatic logic [31:0] corner(input int r, input int c);
    int ew, eh;
    ew = clamp_dim(width_reg, MAX_WIDTH);
    eh = clamp_dim(height_reg, MAX_HEIGHT);
    if (r < 0 || c < 0 || r >= eh || c >= ew) return 32'd0;
    return integral_model[r * ew + c];
  endfunction

  function automatic logic [31:0] box_area(input int ra, input int ca, input int rb,
                                           input int cb);
    return corner(ra, ca) + corner(rb, cb) - corner(ra, cb) - corner(rb, ca);
  endfunction

  // Determinant of the box-filter Hessian in Q.16, truncated and saturated.
  function automatic out_t hessian_det(input int x, input int y);
    out_t r;
    int len, hl, sx;
    logic [31:0] u;
    logic signed [127:0] dxx, dyy, dxy, num, quo, dv;
    logic signed [127:0] top, bot;
    r = '0;
    len = filter_len(scale_reg);
    if (!in_band(x, y, clamp_dim(width_reg, MAX_WIDTH), clamp_dim(height_reg, MAX_HEIGHT),
                 len)) return r;
    hl = len / 2;
    sx = len / 6;
    u = box_area(y - hl - 1, x - sx - 1, y - sx - 1, x + sx)
      - 32'd2 * box_area(y - sx - 1, x - sx - 1, y + sx, x + sx)
      + box_area(y + sx, x - sx - 1, y + hl, x + sx);
    dyy = 128'(signed'(u));
    u = box_area(y - sx - 1, x - hl - 1, y + sx, x - sx - 1)
      - 32'd2 * box_area(y - sx - 1, x - sx - 1, y + sx, x + sx)
      + box_area(y - sx - 1, x + sx, y + sx, x + hl);
    dxx = 128'(signed'(u));
    u = box_area(y - hl, x - hl, y - sx, x - sx)
      - box_area(y - hl, x, y - sx, x + hl - 1)
      - box_area(y, x - hl, y + hl - 1, x - sx)
      + box_area(y, x, y + hl - 1, x + hl - 1);
    dxy = 128'(signed'(u));
    num = 100 * dxx * dyy - 81 * dxy * dxy;
    dv = 100 * len * len * len * len;
    // Signed division truncates toward zero, as the block does.
    quo = (num <<< 16) / dv;
    top = (128'sd1 <<< 47) - 1;
    bot = -(128'sd1 <<< 47);
    if (quo > top) quo = top;
    if (quo < bot) quo = bot;
    r.determinant = quo[47:0];
    r.in_interior = 1'b1;
    return r;
  endfunction

  // Applies one accepted beat to the private model.
  task automatic absorb_beat(input in_t b);
    int ew, eh;
    ew = clamp_dim(width_reg, MAX_WIDTH);
    eh = clamp_dim(height_reg, MAX_HEIGHT);
    if (b.action == ACT_WRITE) begin
      if (b.pos_x < ew && b.pos_y < eh) integral_model[b.pos_y * ew + b.pos_x] = b.integral_word;
    end else begin
      det_expected_q.push_back(hessian_det(b.pos_x, b.pos_y));
    end
  endtask

  // Driver: holds a beat until it is taken, then maybe idles before the next.
  // A beat marked for draining waits until no result is outstanding.
  always @(posedge clk) begin
    job_t j;
    logic nxt_start;
    in_t  nxt_data;
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      nxt_start = start;
      nxt_data = in_data;
      if (start && !busy) begin
        absorb_beat(in_data);
        nxt_start = 1'b0;
      end
      if (!nxt_start && job_q.size() > 0) begin
        j = job_q[0];
        if (!(j.drain && (det_expected_q.size() > 0 || busy))
            && $urandom_range(99) >= send_idle_pct) begin
          nxt_start = 1'b1;
          nxt_data = j.beat;
          void'(job_q.pop_front());
        end
      end
      start <= nxt_start;
      in_data <= nxt_data;
    end
  end

  // Register writes reach the model on the beat of the config channel.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  width_reg <= cfg_data;
        REG_HEIGHT: height_reg <= cfg_data;
        REG_SCALE:  scale_reg <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Monitor: every strobe must match the oldest outstanding determinant.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (det_expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result det=%0d interior=%0b", $time,
                 out_data.determinant, out_data.in_interior);
      end else begin
        want = det_expected_q.pop_front();
        if (out_data.determinant !== want.determinant) begin
          errors++;
          $display("%0t: determinant expected %0d actual %0d", $time,
                   want.determinant, out_data.determinant);
        end
        if (out_data.in_interior !== want.in_interior) begin
          errors++;
          $display("%0t: in_interior expected %0b actual %0b", $time,
                   want.in_interior, out_data.in_interior);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, det_expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus side. It keeps its own view of geometry and of which words have
  // been written, so that a query never reaches an unwritten entry.
  // ---------------------------------------------------------------------------
  bit plan_written [MEM_DEPTH];
  int plan_w = 128, plan_h = 128, plan_len = 9;
  int word_mode = 0;
  int beats_counted = 0, queries_sent = 0, writes_sent = 0;

  function automatic logic [31:0] make_word();
    case (word_mode)
      0:       return $urandom;
      1:       return $urandom_range(4095);
      2:       return 32'hFFFF_FFFF;
      3:       return 32'd0;
      default: return ($urandom_range(1)) ? $urandom : $urandom_range(255);
    endcase
  endfunction

  task automatic push_write(input int x, input int y, input logic [31:0] v);
    job_t j;
    j.beat = '{action: ACT_WRITE, pos_x: x[6:0], pos_y: y[6:0], integral_word: v};
    j.drain = 1'b0;
    job_q.push_back(j);
    writes_sent++;
    // Writes outside the image are dropped by the block and do not count.
    if (x < plan_w && y < plan_h) begin
      plan_written[y * plan_w + x] = 1'b1;
      beats_counted++;
    end
  endtask

  // Issues a query, first writing any corner word it would read unwritten.
  task automatic push_query(input int x, input int y, input bit drain);
    int rows[8], cols[8];
    int hl, sx;
    job_t j;
    if (in_band(x, y, plan_w, plan_h, plan_len)) begin
      hl = plan_len / 2;
      sx = plan_len / 6;
      rows = '{-hl - 1, -sx - 1, sx, hl, -hl, -sx, 0, hl - 1};
      cols = rows;
      foreach (rows[a]) foreach (cols[b])
        if (!plan_written[(y + rows[a]) * plan_w + x + cols[b]])
          push_write(x + cols[b], y + rows[a], make_word());
    end
    j.beat = '{action: ACT_QUERY, pos_x: x[6:0], pos_y: y[6:0],
               integral_word: $urandom};
    j.drain = drain;
    job_q.push_back(j);
    queries_sent++;
    beats_counted++;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (job_q.size() != 0 || start || busy || det_expected_q.size() != 0);
    // A trailing write raises no strobe; give it time to land.
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int w, input int h, input int s);
    write_reg(REG_WIDTH, w[7:0]);
    write_reg(REG_HEIGHT, h[7:0]);
    write_reg(REG_SCALE, s[2:0]);
    plan_w = clamp_dim(w, MAX_WIDTH);
    plan_h = clamp_dim(h, MAX_HEIGHT);
    plan_len = filter_len(s);
  endtask

  int cfg_list[10][3] = '{
    '{128, 128, 4}, '{34, 34, 4}, '{35, 35, 4}, '{1, 1, 0}, '{0, 255, 5},
    '{200, 0, 7}, '{64, 100, 2}, '{128, 128, 3}, '{40, 128, 1}, '{255, 255, 6}
  };

  initial begin
    int goal, pick, hl, cx, cy, x, y, xlo, xhi, ylo, yhi;
    bit has_band;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats at reset geometry (128 x 128, filter 9): corners, band
    // edges on both sides, all-ones and all-zero neighborhoods, full-range
    // words, and one query that waits for the pipeline to empty.
    push_write(0, 0, 32'd0);
    push_write(127, 127, 32'hFFFF_FFFF);
    push_query(0, 0, 1'b0);
    push_query(127, 127, 1'b0);
    push_query(4, 20, 1'b0);
    push_query(123, 20, 1'b0);
    word_mode = 2;
    push_query(5, 5, 1'b0);
    word_mode = 3;
    push_query(122, 122, 1'b0);
    word_mode = 0;
    push_query(60, 60, 1'b0);
    push_query(60, 60, 1'b1);
    word_mode = 1;
    push_query(30, 90, 1'b0);
    wait_idle();

    foreach (cfg_list[p]) begin
      send_idle_pct = (p < 4) ? 16 : (p < 7) ? 73 : 0;
      configure(cfg_list[p][0], cfg_list[p][1], cfg_list[p][2]);
      word_mode = $urandom_range(4);
      hl = plan_len / 2;
      xlo = hl + 1;  xhi = plan_w - hl - 2;
      ylo = hl + 1;  yhi = plan_h - hl - 2;
      has_band = xhi >= xlo && yhi >= ylo;
      if (has_band) begin
        cx = $urandom_range(xhi, xlo);
        cy = $urandom_range(yhi, ylo);
      end
      goal = beats_counted + PHASE_BEATS;
      while (beats_counted < goal) begin
        pick = $urandom_range(99);
        if (pick < 70 && has_band) begin
          // Query clustered around one pixel so neighborhoods are reused.
          x = cx + $urandom_range(6) - 3;
          y = cy + $urandom_range(6) - 3;
          x = (x < xlo) ? xlo : (x > xhi) ? xhi : x;
          y = (y < ylo) ? ylo : (y > yhi) ? yhi : y;
          push_query(x, y, $urandom_range(99) < 3);
        end else if (pick < 82) begin
          push_query($urandom_range(127), $urandom_range(127), 1'b0);
        end else if (pick < 92 || !has_band) begin
          push_write($urandom_range(127), $urandom_range(127), make_word());
        end else begin
          // Overwrite a word under the cluster with a fresh value.
          x = cx + $urandom_range(2 * hl + 2) - hl - 1;
          y = cy + $urandom_range(2 * hl + 2) - hl - 1;
          push_write(x, y, make_word());
        end
      end
      wait_idle();
    end

    $display("Covered %0d queries and %0d writes over %0d geometry/scale settings;",
             queries_sent, writes_sent, 11);
    $display("%0d determinants compared, %0d mismatches.", results_seen, errors);
    if (errors == 0 && det_expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: box_filter_hessian_determinant.f
src/bfhd_pkg.sv
src/bfhd_divider.sv
src/box_filter_hessian_determinant.sv
test/box_filter_hessian_determinant_test.sv
